// ===== rtl/tsp_pkg.sv =====
// Shared constants, types and helpers of the thinning sub-pass unit.
package tsp_pkg;

	// Widest row the line store holds.
	localparam int MAX_WIDTH = 1024;

	// Field widths of the configuration registers.
	localparam int PARITY_W = 1;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 12;
	localparam int ROW_W    = 12;

	// Column counters and line store addressing.
	localparam int COL_W = $clog2(MAX_WIDTH);
	// Width used for column compares: holds column + 1 and any width setting.
	localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_SUB_PASS_PARITY = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 2'd2;

	localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
	localparam int                  MIN_SIZE           = 4;

	// Request opcodes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Line store entry: bit 1 = upper line, bit 0 = middle line.
	localparam int LINE_W = 2;

	typedef struct packed {
		logic              parity;
		logic [CMP_W-1:0]  wm1;     // effective width - 1
		logic [CMP_W-1:0]  eff_w;   // effective width
		logic [ROW_W-1:0]  hm1;     // effective height - 1
		logic [ROW_W-1:0]  eff_h;   // effective height
	} cfg_t;

	// One window column on its way from front to back.
	typedef struct packed {
		logic emit;    // this column produces a result
		logic border;  // the result pixel sits on the frame edge
		logic last;    // the result is the frame's final pixel
		logic up;
		logic mid;
		logic pix;
	} col_item_t;

	function automatic logic [CMP_W-1:0] sat_width(input logic [WIDTH_W-1:0] raw);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(raw);
		if (ext < CMP_W'(MIN_SIZE))
			return CMP_W'(MIN_SIZE);
		if (ext > CMP_W'(MAX_WIDTH))
			return CMP_W'(MAX_WIDTH);
		return ext;
	endfunction

	function automatic logic [ROW_W-1:0] sat_height(input logic [HEIGHT_W-1:0] raw);
		if (raw < HEIGHT_W'(MIN_SIZE))
			return ROW_W'(MIN_SIZE);
		return ROW_W'(raw);
	endfunction

endpackage

// ===== rtl/tsp_if.sv =====
// Request channels of the thinning sub-pass unit: pixels in, results out.
interface tsp_in_if;
	logic valid;
	logic ready;
	logic op;
	logic pixel_in;

	modport source (output valid, output op, output pixel_in, input ready);
	modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface tsp_out_if;
	logic valid;
	logic ready;
	logic pixel_out;
	logic was_deleted;
	logic frame_last;
	logic any_deleted;

	modport source (output valid, output pixel_out, output was_deleted,
		output frame_last, output any_deleted, input ready);
	modport sink   (input valid, input pixel_out, input was_deleted,
		input frame_last, input any_deleted, output ready);
endinterface

// ===== rtl/tsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tsp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tsp_front.sv =====
// Front end: takes requests, tracks raster position, reads and updates the line store.
module tsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  tsp_pkg::cfg_t       cfg,
	tsp_in_if.sink              pixels,
	input  logic                q_full,
	output logic                push,
	output tsp_pkg::col_item_t  push_data
);

	logic [tsp_pkg::COL_W-1:0] in_col_q, out_col_q;
	logic [tsp_pkg::ROW_W-1:0] in_row_q, out_row_q;

	logic                      s1_valid_q;
	logic [tsp_pkg::COL_W-1:0] col_s1;
	logic                      pix_s1, emit_s1, border_s1, last_s1;

	logic                         byp_valid_q;
	logic [tsp_pkg::LINE_W-1:0]   byp_data_q;
	logic [tsp_pkg::LINE_W-1:0]   rdata, line_rd, wdata;

	logic                      in_ready, fire, take, is_flush, inputs_done;
	logic                      emit, border, last, col_wrap, out_wrap;
	logic [tsp_pkg::CMP_W-1:0] col_inc, out_inc;
	logic [tsp_pkg::COL_W-1:0] in_col_nx, out_col_nx;
	logic [tsp_pkg::ROW_W-1:0] in_row_nx, out_row_nx;

	assign in_ready     = !s1_valid_q || !q_full;
	assign pixels.ready = in_ready;
	assign fire         = pixels.valid && in_ready;

	always_comb begin
		is_flush    = (pixels.op == tsp_pkg::OP_FLUSH);
		inputs_done = (in_row_q >= cfg.eff_h);
		// pixels past the frame and flushes before its end are dropped
		take        = is_flush ? inputs_done : !inputs_done;
		emit        = is_flush || (in_row_q >= tsp_pkg::ROW_W'(2))
			|| (in_row_q == tsp_pkg::ROW_W'(1) && in_col_q != '0);

		col_inc   = tsp_pkg::CMP_W'(in_col_q) + tsp_pkg::CMP_W'(1);
		col_wrap  = (col_inc >= cfg.eff_w);
		in_col_nx = col_wrap ? '0 : col_inc[tsp_pkg::COL_W-1:0];
		in_row_nx = (!is_flush && col_wrap) ? in_row_q + tsp_pkg::ROW_W'(1) : in_row_q;

		border = (out_row_q == '0) || (out_row_q >= cfg.hm1) || (out_col_q == '0)
			|| (tsp_pkg::CMP_W'(out_col_q) >= cfg.wm1);
		last   = (out_row_q >= cfg.hm1) && (tsp_pkg::CMP_W'(out_col_q) >= cfg.wm1);

		out_inc    = tsp_pkg::CMP_W'(out_col_q) + tsp_pkg::CMP_W'(1);
		out_wrap   = (out_inc >= cfg.eff_w);
		out_col_nx = out_wrap ? '0 : out_inc[tsp_pkg::COL_W-1:0];
		out_row_nx = out_wrap ? out_row_q + tsp_pkg::ROW_W'(1) : out_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (fire && take) begin
				if (emit && last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					in_col_q <= in_col_nx;
					in_row_q <= in_row_nx;
					if (emit) begin
						out_col_q <= out_col_nx;
						out_row_q <= out_row_nx;
					end
				end
			end
			if (in_ready)
				s1_valid_q <= fire && take;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && take) begin
			col_s1    <= in_col_q;
			pix_s1    <= is_flush ? 1'b0 : pixels.pixel_in;
			emit_s1   <= emit;
			border_s1 <= border;
			last_s1   <= last;
		end
	end

	// same column written and read at one edge: forward the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (fire && take) begin
			byp_valid_q <= push && (col_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && take)
			byp_data_q <= wdata;
	end

	assign line_rd = byp_valid_q ? byp_data_q : rdata;
	assign wdata   = {line_rd[0], pix_s1};
	assign push    = s1_valid_q && !q_full;

	assign push_data = '{emit: emit_s1, border: border_s1, last: last_s1,
		up: line_rd[1], mid: line_rd[0], pix: pix_s1};

	tsp_ram #(
		.WIDTH(tsp_pkg::LINE_W),
		.DEPTH(tsp_pkg::MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (push),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (fire && take),
		.raddr (in_col_q),
		.rdata (rdata)
	);

endmodule

// ===== rtl/tsp_queue.sv =====
// Short queue of window columns between front and back.
module tsp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tsp_pkg::col_item_t  push_data,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output tsp_pkg::col_item_t  head
);

	tsp_pkg::col_item_t          slot_q [tsp_pkg::QUEUE_DEPTH];
	logic [tsp_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
	logic [tsp_pkg::QPTR_W:0]    count_q;

	assign full       = (count_q == (tsp_pkg::QPTR_W+1)'(tsp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == tsp_pkg::QPTR_W'(tsp_pkg::QUEUE_DEPTH - 1))
					? '0 : wptr_q + tsp_pkg::QPTR_W'(1);
			if (pop)
				rptr_q <= (rptr_q == tsp_pkg::QPTR_W'(tsp_pkg::QUEUE_DEPTH - 1))
					? '0 : rptr_q + tsp_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (tsp_pkg::QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (tsp_pkg::QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_data;
	end

endmodule

// ===== rtl/tsp_back.sv =====
// Back end: 3x3 window, deletion test and registered result.
module tsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                parity,
	input  logic                head_valid,
	input  tsp_pkg::col_item_t  head,
	output logic                pop,
	tsp_out_if.source           results
);

	logic [8:0] win_q, win_nx;
	logic       seen_q;
	logic       out_valid_q, pixel_out_q, was_deleted_q, frame_last_q, any_deleted_q;

	logic       out_free, ctr, del, m1, m2;
	logic       nw, we, sw, no, so, ne, ea, se;
	logic [7:0] ring, trans;
	logic [3:0] n_trans, n_set;

	assign out_free = !out_valid_q || results.ready;
	assign pop      = head_valid && (!head.emit || out_free);
	assign win_nx   = {head.pix, head.mid, head.up, win_q[8:3]};

	always_comb begin
		{se, ea, ne, so, ctr, no, sw, we, nw} = win_nx;
		// ring from north clockwise; trans marks 0 -> 1 steps
		ring  = {nw, we, sw, so, se, ea, ne, no};
		trans = ~ring & {ring[0], ring[7:1]};
		n_trans = '0;
		n_set   = '0;
		for (int i = 0; i < 8; i++) begin
			n_trans = n_trans + 4'(trans[i]);
			n_set   = n_set + 4'(ring[i]);
		end
		if (parity) begin
			m1 = no & ea & we;
			m2 = no & so & we;
		end else begin
			m1 = no & ea & so;
			m2 = ea & so & we;
		end
		del = ctr && !head.border && (n_trans == 4'd1) && (n_set >= 4'd2)
			&& (n_set <= 4'd6) && !m1 && !m2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				win_q <= win_nx;
			if (pop && head.emit) begin
				out_valid_q <= 1'b1;
				seen_q      <= head.last ? 1'b0 : (seen_q | del);
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.emit) begin
			pixel_out_q   <= ctr & ~del;
			was_deleted_q <= del;
			frame_last_q  <= head.last;
			any_deleted_q <= head.last & (seen_q | del);
		end
	end

	assign results.valid       = out_valid_q;
	assign results.pixel_out   = pixel_out_q;
	assign results.was_deleted = was_deleted_q;
	assign results.frame_last  = frame_last_q;
	assign results.any_deleted = any_deleted_q;

endmodule

// ===== rtl/binary_thinning_subpass_unit.sv =====
// Top level of the Zhang-Suen thinning sub-pass unit.
//
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+------------
//  pixels   | in  | op, pixel_in                                     | valid/ready
//  results  | out | pixel_out, was_deleted, frame_last, any_deleted  | valid/ready
//  cfg      | in  | cfg_index, cfg_data                              | cfg_we only
//
// One request per cycle while the queue has room; an accepted request passes the stage-1
// register and the queue into the output register, where its result can be taken.
// Results trail pixels by frame_width+1 requests.
// The rate is set by the line store: one read at accept, one write at the push.
// Reset clears counters, window and queue; the line store is not cleared.
// A two-entry queue and the output register let either side stall on its own.
module binary_thinning_subpass_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	tsp_in_if.sink                           pixels,
	tsp_out_if.source                        results
);

	tsp_pkg::cfg_t      cfg_q;
	logic               push, q_full, pop, head_valid;
	tsp_pkg::col_item_t push_data, head;

	logic [tsp_pkg::CMP_W-1:0] new_w;
	logic [tsp_pkg::ROW_W-1:0] new_h;

	// sizes are held already clamped to their legal range
	assign new_w = tsp_pkg::sat_width(cfg_data[tsp_pkg::WIDTH_W-1:0]);
	assign new_h = tsp_pkg::sat_height(cfg_data[tsp_pkg::HEIGHT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.parity <= 1'b0;
			cfg_q.eff_w  <= tsp_pkg::sat_width(tsp_pkg::FRAME_WIDTH_RESET);
			cfg_q.wm1    <= tsp_pkg::sat_width(tsp_pkg::FRAME_WIDTH_RESET)
				- tsp_pkg::CMP_W'(1);
			cfg_q.eff_h  <= tsp_pkg::sat_height(tsp_pkg::FRAME_HEIGHT_RESET);
			cfg_q.hm1    <= tsp_pkg::sat_height(tsp_pkg::FRAME_HEIGHT_RESET)
				- tsp_pkg::ROW_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsp_pkg::REG_SUB_PASS_PARITY: begin
					cfg_q.parity <= cfg_data[0];
				end
				tsp_pkg::REG_FRAME_WIDTH: begin
					cfg_q.eff_w <= new_w;
					cfg_q.wm1   <= new_w - tsp_pkg::CMP_W'(1);
				end
				tsp_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.eff_h <= new_h;
					cfg_q.hm1   <= new_h - tsp_pkg::ROW_W'(1);
				end
				default: begin
					// unused index: write dropped
				end
			endcase
		end
	end

	// front: accept, classify, line store access
	tsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pixels    (pixels),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: window shift, deletion test, result register
	tsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.parity     (cfg_q.parity),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule

// ===== rtl/tsp_checker.sv =====
// Port-level checks of the thinning sub-pass unit, bound to the top level.
module tsp_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic pixel_out,
	input logic was_deleted,
	input logic frame_last,
	input logic any_deleted
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
			&& $stable({pixel_out, was_deleted, frame_last, any_deleted}))
		else $error("result changed while stalled");

	a_any_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_last |-> !any_deleted)
		else $error("any_deleted set away from frame end");

	a_del_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && was_deleted |-> !pixel_out)
		else $error("deleted pixel still set");

	a_last_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_last && was_deleted |-> any_deleted)
		else $error("frame summary misses final deletion");

endmodule

bind binary_thinning_subpass_unit tsp_checker u_tsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.pixel_out   (results.pixel_out),
	.was_deleted (results.was_deleted),
	.frame_last  (results.frame_last),
	.any_deleted (results.any_deleted)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the thinning sub-pass unit: streamed frames against a local model.
module testbench;
	import tsp_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 3;
	// Watchdog limit, far above what a full run needs.
	localparam int CYCLE_LIMIT   = 100000;
	// Wait before a write, so that a request still in flight can settle.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int IDLE_PERCENT  = 20;
	// Pixels of the tall frame sent before its height is cut back.
	localparam int TALL_PIXELS   = 200;

	// Index 3 maps to no register; a write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	// 4x4 directed frame, bit = row*4 + col: a 2-wide vertical bar in the middle columns.
	// Under the second parity the upper-left interior pixel goes, its neighbour stays.
	localparam bit [15:0] BAR_SHAPE = 16'h0666;

	typedef struct packed {
		logic pixel_out;
		logic was_deleted;
		logic frame_last;
		logic any_deleted;
	} sub_pass_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tsp_in_if  pixel_bus ();
	tsp_out_if result_bus ();

	binary_thinning_subpass_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixel_bus),
		.results   (result_bus)
	);

	// ------------------------------------------------------------------
	// Local model of the sub-pass: own copy of registers, line stores,
	// window and raster counters.
	// ------------------------------------------------------------------
	bit                parity_q;
	bit [WIDTH_W-1:0]  width_q;
	bit [HEIGHT_W-1:0] height_q;

	// Never-written entries read as zero; they only ever sit beside border pixels.
	bit                upper_store  [MAX_WIDTH];
	bit                middle_store [MAX_WIDTH];
	// Window: [2:0] oldest column (up, mid, new), [5:3] centre column, [8:6] newest.
	bit [8:0]          window_q;
	int unsigned       in_col, in_row, out_col, out_row;
	bit                deleted_seen_q;

	// Results still owed by the block, oldest first.
	sub_pass_result_t  pending_pixels [$];

	bit gaps_on;        // random idling on both sides
	bit frame_closed;   // model has produced the frame's final pixel
	int fed_count;      // requests that moved the raster on
	int checked_count;
	int frame_count;
	int cleared_count;
	int error_count;

	function automatic int unsigned eff_width();
		int unsigned w;
		w = 32'(width_q);
		if (w < MIN_SIZE)
			w = MIN_SIZE;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = 32'(height_q);
		if (h < MIN_SIZE)
			h = MIN_SIZE;
		return h;
	endfunction

	// Push one column (upper, middle, new pixel) through the line stores into the window.
	function automatic void shift_column(int unsigned col, bit pix);
		bit up, mid;
		up = upper_store[col];
		mid = middle_store[col];
		upper_store[col] = mid;
		middle_store[col] = pix;
		window_q = {pix, mid, up, window_q[8:3]};
	endfunction

	// Decide the window centre and queue the result for out_row/out_col.
	function automatic void decide_centre(int unsigned w, int unsigned h);
		sub_pass_result_t r;
		bit ctr, del, border, last, prod_a, prod_b;
		bit nw, ww, sw, nn, ss, ne, ee, se;
		bit ring [9];
		int rises, set_count, i;
		ctr = window_q[4];
		del = 1'b0;
		border = (out_row == 0) || (out_row >= h - 1) || (out_col == 0) || (out_col >= w - 1);
		if (!border && ctr) begin
			nw = window_q[0]; ww = window_q[1]; sw = window_q[2];
			nn = window_q[3]; ss = window_q[5];
			ne = window_q[6]; ee = window_q[7]; se = window_q[8];
			ring = '{nn, ne, ee, se, ss, sw, ww, nw, nn};
			rises = 0;
			set_count = 0;
			for (i = 0; i < 8; i++) begin
				if (!ring[i] && ring[i+1])
					rises++;
				set_count += int'(ring[i]);
			end
			if (parity_q) begin
				prod_a = nn & ee & ww;
				prod_b = nn & ss & ww;
			end else begin
				prod_a = nn & ee & ss;
				prod_b = ee & ss & ww;
			end
			del = (rises == 1) && (set_count >= 2) && (set_count <= 6) && !prod_a && !prod_b;
		end
		deleted_seen_q |= del;
		last = (out_row >= h - 1) && (out_col >= w - 1);
		r.pixel_out   = ctr & ~del;
		r.was_deleted = del;
		r.frame_last  = last;
		r.any_deleted = last & deleted_seen_q;
		pending_pixels = {pending_pixels, r};
		cleared_count += int'(del);
		if (last) begin
			// frame done: counters and the deletion flag start afresh
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			deleted_seen_q = 1'b0;
			frame_closed = 1'b1;
			frame_count++;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row = (out_row + 1) & 32'hFFF;
			end
		end
	endfunction

	// Apply one accepted request to the model.
	function automatic void predict_thinning(logic op, logic pix);
		int unsigned w, h;
		bit inputs_done, gives_result;
		w = eff_width();
		h = eff_height();
		inputs_done = in_row >= h;
		if (op == OP_PIXEL) begin
			// stray pixel while the drain is still running
			if (inputs_done)
				return;
			// first row and one pixel of the second fill the window only
			gives_result = (in_row >= 2) || (in_row == 1 && in_col >= 1);
			shift_column(in_col, pix);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row = (in_row + 1) & 32'hFFF;
			end
			fed_count++;
			if (gives_result)
				decide_centre(w, h);
		end else begin
			// flush before the last pixel has arrived does nothing
			if (!inputs_done)
				return;
			shift_column(in_col, 1'b0);
			in_col++;
			if (in_col >= w)
				in_col = 0;
			fed_count++;
			decide_centre(w, h);
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock, watchdog, result side
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timed out after %0d cycles, %0d results still owed", CYCLE_LIMIT,
			pending_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

	// Result ready: changes on the falling edge, idles like the sender.
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_bus.ready = !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	function automatic void compare_field(string name, logic want, logic got);
		if (got !== want) begin
			$display("t=%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		sub_pass_result_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready) begin
			if (pending_pixels.size() == 0) begin
				$display("t=%0t: result with none expected, got pixel_out %0b frame_last %0b",
					$time, result_bus.pixel_out, result_bus.frame_last);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				compare_field("pixel_out",   want.pixel_out,   result_bus.pixel_out);
				compare_field("was_deleted", want.was_deleted, result_bus.was_deleted);
				compare_field("frame_last",  want.frame_last,  result_bus.frame_last);
				compare_field("any_deleted", want.any_deleted, result_bus.any_deleted);
				checked_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side and register writes
	// ------------------------------------------------------------------

	// One request: optional idle cycles, then hold until accepted. Valid stays
	// high on return so back-to-back requests run at full rate.
	task automatic send_request(logic op, logic pix);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			pixel_bus.valid = 1'b0;
			@(negedge clk);
		end
		pixel_bus.valid    = 1'b1;
		pixel_bus.op       = op;
		pixel_bus.pixel_in = pix;
		do
			@(posedge clk);
		while (!pixel_bus.ready);
		predict_thinning(op, pix);
	endtask

	// Stop sending and wait for every owed result.
	task automatic drain_results();
		@(negedge clk);
		pixel_bus.valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		@(posedge clk);
		case (index)
			REG_SUB_PASS_PARITY: parity_q = data[0];
			REG_FRAME_WIDTH:     width_q  = data[WIDTH_W-1:0];
			REG_FRAME_HEIGHT:    height_q = data[HEIGHT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// All three registers, once the block is idle; a last pixel may still be
	// in flight without owing a result, hence the settle time.
	task automatic configure(logic [CFG_DATA_W-1:0] parity, logic [CFG_DATA_W-1:0] width,
		logic [CFG_DATA_W-1:0] height);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_SUB_PASS_PARITY, parity);
		write_reg(REG_FRAME_WIDTH, width);
		write_reg(REG_FRAME_HEIGHT, height);
	endtask

	// Rest of a frame: pixels until the model has them all, then flushes
	// until the final pixel is out. Noisy frames mix in stray requests.
	// pause_at >= 0 holds the sender at that pixel until nothing is owed.
	task automatic fill_frame(int density, bit noisy, int pause_at);
		int n;
		n = 0;
		while (!frame_closed && in_row < eff_height()) begin
			if (noisy && $urandom_range(99) < 4)
				send_request(OP_FLUSH, 1'($urandom_range(1)));
			if (n == pause_at)
				drain_results();
			send_request(OP_PIXEL, $urandom_range(99) < density);
			n++;
		end
		while (!frame_closed) begin
			if (noisy && $urandom_range(99) < 4)
				send_request(OP_PIXEL, 1'($urandom_range(1)));
			send_request(OP_FLUSH, 1'($urandom_range(1)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Smallest frame, sizes written below range, stray flush and pixel, spare index.
	task automatic test_directed_small();
		int i;
		// parity from data bit 0 only; width 3 with bit 11 set -> 4; height 0 -> 4
		configure(12'hFFF, 12'h803, 12'h000);
		write_reg(REG_SPARE, 12'hA5C);
		frame_closed = 1'b0;
		for (i = 0; i < 16; i++) begin
			if (i == 7)
				send_request(OP_FLUSH, 1'b1);   // pixels still due: no effect
			send_request(OP_PIXEL, BAR_SHAPE[i]);
		end
		send_request(OP_FLUSH, 1'b0);
		send_request(OP_PIXEL, 1'b1);           // drain running: no effect
		while (!frame_closed)
			send_request(OP_FLUSH, 1'b1);
		send_request(OP_FLUSH, 1'b0);           // new frame has begun: no effect
	endtask

	// Width saturated from all ones; part of the first row goes in, then the
	// row is cut back under the column counter, which wraps on the next pixel.
	task automatic test_widest_rows();
		int i;
		configure(12'h000, 12'h7FF, 12'h004);
		frame_closed = 1'b0;
		for (i = 0; i < 40; i++)
			send_request(OP_PIXEL, 1'($urandom_range(1)));
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_FRAME_WIDTH, 12'd12);
		fill_frame(50, 1'b0, -1);
	endtask

	// Tallest frame at the narrowest width; the sender stops once mid-frame
	// until the result side has caught up. The height is then cut below the
	// current row, so the next result closes the frame.
	task automatic test_tallest_frame();
		int i;
		configure(12'h001, 12'h004, 12'hFFF);
		frame_closed = 1'b0;
		for (i = 0; i < TALL_PIXELS; i++) begin
			if (i == TALL_PIXELS / 2)
				drain_results();
			send_request(OP_PIXEL, $urandom_range(99) < 60);
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_FRAME_HEIGHT, 12'd30);
		fill_frame(60, 1'b1, -1);
	endtask

	// Sizes rewritten part way through a frame, while the block is idle.
	// A full 14-wide frame first puts known data in every column the resize reaches.
	task automatic test_mid_frame_resize();
		int i;
		configure(12'h000, 12'd14, 12'd4);
		frame_closed = 1'b0;
		fill_frame(50, 1'b0, -1);
		configure(12'h000, 12'd10, 12'd8);
		frame_closed = 1'b0;
		for (i = 0; i < 45; i++)
			send_request(OP_PIXEL, 1'($urandom_range(1)));
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(14, 4)));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(12, 4)));
		fill_frame(50, 1'b0, -1);
	endtask

	// Random frames, mostly small; one stretch with no idling on either side.
	task automatic test_random_frames();
		int start, r, w, h, density, pause_at;
		bit noisy;
		start = fed_count;
		while (fed_count - start < RANDOM_ITEMS) begin
			gaps_on = (fed_count - start < 500) || (fed_count - start >= 900);
			r = $urandom_range(99);
			if (r < 5)
				w = $urandom_range(3);
			else if (r < 15)
				w = $urandom_range(48, 13);
			else
				w = $urandom_range(12, 4);
			r = $urandom_range(99);
			if (r < 5)
				h = $urandom_range(3);
			else if (r < 10)
				h = $urandom_range(40, 11);
			else
				h = $urandom_range(10, 4);
			// bits above each register's width ride along and are dropped
			configure(CFG_DATA_W'($urandom_range(4095)),
				CFG_DATA_W'(w + 2048 * $urandom_range(1)), CFG_DATA_W'(h));
			density  = $urandom_range(90, 15);
			noisy    = $urandom_range(2) == 0;
			pause_at = ($urandom_range(7) == 0) ? int'($urandom_range(30)) : -1;
			frame_closed = 1'b0;
			fill_frame(density, noisy, pause_at);
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_SUB_PASS_PARITY;
		cfg_data           = '0;
		pixel_bus.valid    = 1'b0;
		pixel_bus.op       = OP_PIXEL;
		pixel_bus.pixel_in = 1'b0;
		gaps_on            = 1'b1;
		parity_q           = 1'b0;
		width_q            = FRAME_WIDTH_RESET;
		height_q           = FRAME_HEIGHT_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_small();
		test_widest_rows();
		test_tallest_frame();
		test_mid_frame_resize();
		test_random_frames();

		drain_results();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d raster requests over %0d frames, %0d pixels cleared.",
			checked_count, fed_count, frame_count, cleared_count);
		$display("4x4 and random frames, sizes out of range and cut mid-frame, both parities, strays.");
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tsp_pkg.sv
rtl/tsp_if.sv
rtl/tsp_ram.sv
rtl/tsp_front.sv
rtl/tsp_queue.sv
rtl/tsp_back.sv
rtl/binary_thinning_subpass_unit.sv
rtl/tsp_checker.sv
tb/sv/testbench.sv
